[rtl/hsi2rgb_pkg.sv]
package hsi2rgb_pkg;

    localparam int HUE_BITS_DEF      = 12;
    localparam int SAT_FRAC_BITS_DEF = 12;

    localparam int CORDIC_STEPS = 16;
    localparam int DIV_BITS     = 31;
    localparam int ACC_W        = 34;

    localparam logic signed [ACC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [29:0]             HALF_SQRT3  = 30'd929887697;
    localparam logic [31:0]             Q30_ONE     = 32'd1073741824;
    localparam logic [31:0]             Q29_HALF    = 32'd536870912;
    localparam logic [32:0]             RECIP3      = 33'h0AAAAAAAB;

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

    // floor(v / 3) by reciprocal multiply, exact for every 32-bit v
    function automatic logic [30:0] div3(input logic [31:0] v);
        logic [64:0] p;
        p = 65'(v) * 65'(RECIP3);
        return p[63:33];
    endfunction

endpackage

[rtl/hsi2rgb_if.sv]
interface hsi2rgb_in_if #(
    parameter int HUE_BITS      = 12,
    parameter int SAT_FRAC_BITS = 12
);
    logic                     valid;
    logic                     ready;
    logic [HUE_BITS-1:0]      hue_angle;
    logic [SAT_FRAC_BITS:0]   sat_value;

    modport source (output valid, output hue_angle, output sat_value, input ready);
    modport sink   (input valid, input hue_angle, input sat_value, output ready);
endinterface

interface hsi2rgb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);
endinterface

[rtl/hsi2rgb_cordic.sv]
module hsi2rgb_cordic
    import hsi2rgb_pkg::*;
#(
    parameter int SIDE_W = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_pipe_ctl                i_ctl,
    input  logic signed [ACC_W-1:0]  i_z,
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    output logic signed [ACC_W-1:0]  o_x,
    output logic signed [ACC_W-1:0]  o_y,
    output logic [SIDE_W-1:0]        o_side
);

    logic signed [ACC_W-1:0] r_x    [CORDIC_STEPS];
    logic signed [ACC_W-1:0] r_y    [CORDIC_STEPS];
    logic signed [ACC_W-1:0] r_z    [CORDIC_STEPS];
    logic [SIDE_W-1:0]       r_side [CORDIC_STEPS];
    logic                    r_v    [CORDIC_STEPS];

    for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_step
        logic signed [ACC_W-1:0] x_cur, y_cur, z_cur, ang;
        logic [SIDE_W-1:0]       side_cur;
        logic                    v_cur;

        if (gi == 0) begin : g_first
            assign x_cur    = CORDIC_GAIN;
            assign y_cur    = '0;
            assign z_cur    = i_z;
            assign side_cur = i_side;
            assign v_cur    = i_ctl.valid;
        end else begin : g_next
            assign x_cur    = r_x[gi-1];
            assign y_cur    = r_y[gi-1];
            assign z_cur    = r_z[gi-1];
            assign side_cur = r_side[gi-1];
            assign v_cur    = r_v[gi-1];
        end

        assign ang = $signed({2'b00, ATAN_TURNS[gi]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gi] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[gi] <= v_cur;
            end
        end

        // a zero residual rotates in the positive direction
        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_side[gi] <= side_cur;
                if (!z_cur[ACC_W-1]) begin
                    r_x[gi] <= x_cur - (y_cur >>> gi);
                    r_y[gi] <= y_cur + (x_cur >>> gi);
                    r_z[gi] <= z_cur - ang;
                end else begin
                    r_x[gi] <= x_cur + (y_cur >>> gi);
                    r_y[gi] <= y_cur - (x_cur >>> gi);
                    r_z[gi] <= z_cur + ang;
                end
            end
        end
    end

    assign o_valid = r_v[CORDIC_STEPS-1];
    assign o_x     = r_x[CORDIC_STEPS-1];
    assign o_y     = r_y[CORDIC_STEPS-1];
    assign o_side  = r_side[CORDIC_STEPS-1];

endmodule

[rtl/hsi2rgb_div.sv]
module hsi2rgb_div
    import hsi2rgb_pkg::*;
#(
    parameter int SIDE_W = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_pipe_ctl            i_ctl,
    input  logic [DIV_BITS-1:0]  i_num,
    input  logic [DIV_BITS-1:0]  i_den,
    input  logic                 i_neg,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [DIV_BITS-1:0]  o_quo,
    output logic                 o_neg,
    output logic [SIDE_W-1:0]    o_side
);

    // restoring division of i_num * 2^30 by i_den, one quotient bit per stage
    logic [DIV_BITS-1:0] r_rem  [DIV_BITS];
    logic [DIV_BITS-1:0] r_quo  [DIV_BITS];
    logic [DIV_BITS-1:0] r_den  [DIV_BITS];
    logic                r_neg  [DIV_BITS];
    logic [SIDE_W-1:0]   r_side [DIV_BITS];
    logic                r_v    [DIV_BITS];

    for (genvar gj = 0; gj < DIV_BITS; gj++) begin : g_bit
        logic [DIV_BITS-1:0] rem_cur, quo_cur, den_cur;
        logic [DIV_BITS:0]   trial;
        logic                bit_in, neg_cur, v_cur;
        logic [SIDE_W-1:0]   side_cur;

        if (gj == 0) begin : g_first
            assign rem_cur  = {1'b0, i_num[DIV_BITS-1:1]};
            assign bit_in   = i_num[0];
            assign quo_cur  = '0;
            assign den_cur  = i_den;
            assign neg_cur  = i_neg;
            assign side_cur = i_side;
            assign v_cur    = i_ctl.valid;
        end else begin : g_next
            assign rem_cur  = r_rem[gj-1];
            assign bit_in   = 1'b0;
            assign quo_cur  = r_quo[gj-1];
            assign den_cur  = r_den[gj-1];
            assign neg_cur  = r_neg[gj-1];
            assign side_cur = r_side[gj-1];
            assign v_cur    = r_v[gj-1];
        end

        assign trial = {rem_cur, bit_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gj] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[gj] <= v_cur;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_den[gj]  <= den_cur;
                r_neg[gj]  <= neg_cur;
                r_side[gj] <= side_cur;
                if (trial >= {1'b0, den_cur}) begin
                    r_rem[gj] <= DIV_BITS'(trial - {1'b0, den_cur});
                    r_quo[gj] <= {quo_cur[DIV_BITS-2:0], 1'b1};
                end else begin
                    r_rem[gj] <= trial[DIV_BITS-1:0];
                    r_quo[gj] <= {quo_cur[DIV_BITS-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[DIV_BITS-1];
    assign o_quo   = r_quo[DIV_BITS-1];
    assign o_neg   = r_neg[DIV_BITS-1];
    assign o_side  = r_side[DIV_BITS-1];

endmodule

[rtl/hsi_to_rgb_pixel_core.sv]
// HSI to RGB pixel converter, fully pipelined.
// Throughput while the skid register is empty: one pixel per cycle; the 16 CORDIC
// stages and the 31-stage tangent divider each retire one step per cycle.
// A one-entry skid register absorbs the first stalled cycle at the output.
// Reset (i_rst_n low, synchronous) clears all valid bits and sets the level to 0.
module hsi_to_rgb_pixel_core
    import hsi2rgb_pkg::*;
#(
    parameter int HUE_BITS      = HUE_BITS_DEF,
    parameter int SAT_FRAC_BITS = SAT_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    hsi2rgb_in_if.sink  i_pix,
    hsi2rgb_out_if.source o_pix
);

    localparam int SAT_W  = SAT_FRAC_BITS + 1;
    localparam int SIDE_W = SAT_W + 3;

    logic [7:0] r_level;
    logic       en;

    logic       r_skid_valid;
    logic [7:0] r_skid_r, r_skid_g, r_skid_b;
    logic       r_out_valid;
    logic [7:0] r_out_r, r_out_g, r_out_b;

    assign en        = !r_skid_valid;
    assign i_pix.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_cfg_we) begin
            r_level <= i_cfg_data;
        end
    end

    // stage A: sector, local angle, clamped saturation
    logic [HUE_BITS+1:0]      h3;
    logic signed [HUE_BITS:0] d;
    logic [HUE_BITS-1:0]      mag;
    logic [SAT_W-1:0]         sat_c;
    logic                     r_a_valid, r_a_neg, r_a_zero;
    logic [1:0]               r_a_sector;
    logic [31:0]              r_a_v;
    logic [SAT_W-1:0]         r_a_sat;

    assign h3    = {2'b00, i_pix.hue_angle} + {1'b0, i_pix.hue_angle, 1'b0};
    assign d     = $signed({1'b0, h3[HUE_BITS-1:0]})
                 - $signed({2'b01, {(HUE_BITS-1){1'b0}}});
    assign mag   = d[HUE_BITS] ? HUE_BITS'(-d) : d[HUE_BITS-1:0];
    assign sat_c = (i_pix.sat_value > {1'b1, {SAT_FRAC_BITS{1'b0}}})
                 ? {1'b1, {SAT_FRAC_BITS{1'b0}}} : i_pix.sat_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_sector <= h3[HUE_BITS+1:HUE_BITS];
            r_a_neg    <= d[HUE_BITS];
            r_a_v      <= {mag, {(32-HUE_BITS){1'b0}}} + 32'd1;
            r_a_sat    <= sat_c;
            r_a_zero   <= (sat_c == '0);
        end
    end

    // stage B: residual angle in 2^-32 turn
    logic                    r_b_valid;
    logic signed [ACC_W-1:0] r_b_z;
    logic [SIDE_W-1:0]       r_b_side;
    logic signed [ACC_W-1:0] zmag;

    assign zmag = $signed({3'b000, div3(r_a_v)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_z    <= r_a_neg ? -zmag : zmag;
            r_b_side <= {r_a_sector, r_a_zero, r_a_sat};
        end
    end

    logic                    cor_valid;
    logic signed [ACC_W-1:0] cor_x, cor_y;
    logic [SIDE_W-1:0]       cor_side;
    t_pipe_ctl               cor_ctl;

    assign cor_ctl.en    = en;
    assign cor_ctl.valid = r_b_valid;

    hsi2rgb_cordic #(.SIDE_W(SIDE_W)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cor_ctl),
        .i_z     (r_b_z),
        .i_side  (r_b_side),
        .o_valid (cor_valid),
        .o_x     (cor_x),
        .o_y     (cor_y),
        .o_side  (cor_side)
    );

    // stage C: divider operands
    logic                r_c_valid, r_c_neg;
    logic [DIV_BITS-1:0] r_c_num, r_c_den;
    logic [SIDE_W-1:0]   r_c_side;
    logic signed [ACC_W-1:0] ymag;

    assign ymag = cor_y[ACC_W-1] ? -cor_y : cor_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= cor_valid;
        end
    end

    // a non-positive cosine is taken as one
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_num  <= ymag[DIV_BITS-1:0];
            r_c_neg  <= cor_y[ACC_W-1];
            r_c_den  <= (!cor_x[ACC_W-1] && cor_x != '0) ? cor_x[DIV_BITS-1:0]
                                                          : DIV_BITS'(1);
            r_c_side <= cor_side;
        end
    end

    logic                div_valid, div_neg;
    logic [DIV_BITS-1:0] div_quo;
    logic [SIDE_W-1:0]   div_side;
    t_pipe_ctl           div_ctl;

    assign div_ctl.en    = en;
    assign div_ctl.valid = r_c_valid;

    hsi2rgb_div #(.SIDE_W(SIDE_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (r_c_num),
        .i_den   (r_c_den),
        .i_neg   (r_c_neg),
        .i_side  (r_c_side),
        .o_valid (div_valid),
        .o_quo   (div_quo),
        .o_neg   (div_neg),
        .o_side  (div_side)
    );

    // stage R: ratio = 1/2 - (sqrt3/2) * tan
    logic [60:0]        rprod;
    logic signed [32:0] rm;
    logic               r_r_valid;
    logic signed [32:0] r_r_ratio;
    logic [SIDE_W-1:0]  r_r_side;

    assign rprod = 61'(div_quo) * 61'(HALF_SQRT3);
    assign rm    = $signed({2'b00, rprod[60:30]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (en) begin
            r_r_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r_ratio <= $signed({1'b0, Q29_HALF}) - (div_neg ? -rm : rm);
            r_r_side  <= div_side;
        end
    end

    // stage P: S * ratio and the minor channel
    logic [SAT_W-1:0]       p_sat;
    logic [31:0]            ra;
    logic [SAT_W+31:0]      pprod;
    logic signed [34:0]     pm;
    logic [30:0]            s30;
    logic                   r_p_valid;
    logic signed [34:0]     r_p_num;
    logic [30:0]            r_p_minor;
    logic [2:0]             r_p_ctl;

    assign p_sat = r_r_side[SAT_W-1:0];
    assign ra    = r_r_ratio[32] ? 32'(-r_r_ratio) : r_r_ratio[31:0];
    assign pprod = (SAT_W+32)'(p_sat) * (SAT_W+32)'(ra);
    assign pm    = $signed({2'b00, pprod[SAT_FRAC_BITS+32:SAT_FRAC_BITS]});
    assign s30   = {p_sat, {(30-SAT_FRAC_BITS){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= r_r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_num   <= $signed({3'b000, Q30_ONE}) + (r_r_ratio[32] ? -pm : pm);
            r_p_minor <= div3(Q30_ONE - {1'b0, s30});
            r_p_ctl   <= r_r_side[SIDE_W-1:SAT_W];
        end
    end

    // stage M: major and rest
    logic [30:0]        major;
    logic signed [32:0] rest;
    logic               r_m_valid;
    logic [30:0]        r_m_minor, r_m_major, r_m_rest;
    logic [2:0]         r_m_ctl;

    assign major = r_p_num[34] ? 31'd0 : div3(r_p_num[31:0]);
    assign rest  = $signed({1'b0, Q30_ONE}) - $signed({2'b00, r_p_minor})
                 - $signed({2'b00, major});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_minor <= r_p_minor;
            r_m_major <= major;
            r_m_rest  <= rest[32] ? 31'd0 : rest[30:0];
            r_m_ctl   <= r_p_ctl;
        end
    end

    // stage O: sector routing, scale by 3 * level, saturate
    function automatic logic [7:0] scale(input logic [7:0] lvl, input logic [30:0] c);
        logic [41:0] p;
        p = 42'(lvl) * 42'd3 * 42'(c) + 42'(Q29_HALF);
        return (p[41:30] > 12'd255) ? 8'd255 : p[37:30];
    endfunction

    logic [30:0] ch_r, ch_g, ch_b;
    logic [1:0]  sector;
    logic        zero_sat;

    assign sector   = r_m_ctl[2:1];
    assign zero_sat = r_m_ctl[0];

    always_comb begin
        case (sector)
            2'd0: begin
                ch_b = r_m_minor; ch_r = r_m_major; ch_g = r_m_rest;
            end
            2'd1: begin
                ch_r = r_m_minor; ch_g = r_m_major; ch_b = r_m_rest;
            end
            default: begin
                ch_g = r_m_minor; ch_b = r_m_major; ch_r = r_m_rest;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_r <= zero_sat ? r_level : scale(r_level, ch_r);
            r_out_g <= zero_sat ? r_level : scale(r_level, ch_g);
            r_out_b <= zero_sat ? r_level : scale(r_level, ch_b);
        end
    end

    // hold a result in the skid register when the pipe advances into a stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (o_pix.ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_out_valid && !o_pix.ready) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            r_skid_r <= r_out_r;
            r_skid_g <= r_out_g;
            r_skid_b <= r_out_b;
        end
    end

    assign o_pix.valid     = r_skid_valid || r_out_valid;
    assign o_pix.red_out   = r_skid_valid ? r_skid_r : r_out_r;
    assign o_pix.green_out = r_skid_valid ? r_skid_g : r_out_g;
    assign o_pix.blue_out  = r_skid_valid ? r_skid_b : r_out_b;

`ifndef NO_ASSERTIONS
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !o_pix.ready))
        else $error("skid filled without a stalled result");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !o_pix.ready) |=> (r_skid_valid && $stable(r_skid_r)
            && $stable(r_skid_g) && $stable(r_skid_b)))
        else $error("stalled skid entry lost or changed");

    a_pipe_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |=> ($stable(r_out_valid) && $stable(r_out_r)))
        else $error("pipeline advanced while skid full");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pix.valid)
        else $error("output valid after reset");
`endif

endmodule

[tb/hsi_to_rgb_pixel_core_tb.sv]
`timescale 1ns / 100ps

module hsi_to_rgb_pixel_core_tb;

    localparam int HB = 12;
    localparam int SB = 12;
    localparam int LATENCY = 54;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct {
        logic [HB-1:0] hue;
        logic [SB:0]   sat;
        logic          typed;
        t_rgb          rgb;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [7:0] i_cfg_data = 8'd0;

    hsi2rgb_in_if #(.HUE_BITS(HB), .SAT_FRAC_BITS(SB)) pix_in ();
    hsi2rgb_out_if pix_out ();

    hsi_to_rgb_pixel_core #(.HUE_BITS(HB), .SAT_FRAC_BITS(SB)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in.sink),
        .o_pix      (pix_out.source)
    );

    always #6 i_clk = ~i_clk;

    logic [7:0] level_model = 8'd0;
    t_rgb       pending_rgb[$];
    int         errors = 0;
    int         send_gap_pct = 0;
    int         recv_stall_pct = 0;
    bit         hold_off = 1'b0;
    bit         all_sent = 1'b0;

    localparam longint ATAN_T [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    function automatic longint fshift(longint v, int n);
        if (v >= 0) return v >>> n;
        return -((-v - 1) >>> n) - 1;
    endfunction

    function automatic logic [7:0] scale_q30(longint c);
        longint v;
        v = (longint'(level_model) * 3 * c + (longint'(1) << 29)) >>> 30;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic t_rgb hsi_to_rgb(logic [HB-1:0] hue, logic [SB:0] sat_in);
        longint sat, h3, sector, lcl, d, mag, z, x, y, dx, dy, cosv, tanq, ratio;
        longint s30, minor, major, rest, r, g, b;
        t_rgb res;
        sat = sat_in;
        if (sat > (1 << SB)) sat = 1 << SB;
        if (sat == 0) begin
            res = '{level_model, level_model, level_model};
            return res;
        end
        h3 = longint'(hue) * 3;
        sector = h3 >>> HB;
        lcl = h3 - (sector << HB);
        d = lcl - (longint'(1) << (HB - 1));
        mag = (d < 0) ? -d : d;
        mag = ((mag << (32 - HB)) + 1) / 3;
        z = (d < 0) ? -mag : mag;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_T[i];
            end else begin
                x += dx; y -= dy; z += ATAN_T[i];
            end
        end
        cosv = (x > 0) ? x : 1;
        tanq = (y * (longint'(1) << 30)) / cosv;
        ratio = (longint'(1) << 29) - (longint'(929887697) * tanq) / (longint'(1) << 30);
        s30 = sat << (30 - SB);
        minor = ((longint'(1) << 30) - s30) / 3;
        if (minor < 0) minor = 0;
        major = ((longint'(1) << 30) + (s30 * ratio) / (longint'(1) << 30)) / 3;
        if (major < 0) major = 0;
        rest = (longint'(1) << 30) - minor - major;
        if (rest < 0) rest = 0;
        if (sector == 0) begin
            b = minor; r = major; g = rest;
        end else if (sector == 1) begin
            r = minor; g = major; b = rest;
        end else begin
            g = minor; b = major; r = rest;
        end
        res.red = scale_q30(r);
        res.green = scale_q30(g);
        res.blue = scale_q30(b);
        return res;
    endfunction

    // directed rows: typed results only for gray pixels
    t_row dir_rows[] = '{
        '{12'd0,    13'd0,    1'b1, '{8'd0, 8'd0, 8'd0}},
        '{12'd4095, 13'd0,    1'b1, '{8'd0, 8'd0, 8'd0}},
        '{12'd0,    13'd4096, 1'b0, '0},
        '{12'd1365, 13'd4096, 1'b0, '0},
        '{12'd1366, 13'd4096, 1'b0, '0},
        '{12'd2730, 13'd4096, 1'b0, '0},
        '{12'd2731, 13'd4096, 1'b0, '0},
        '{12'd4095, 13'd4096, 1'b0, '0},
        '{12'd682,  13'd8191, 1'b0, '0},
        '{12'd2048, 13'd4097, 1'b0, '0},
        '{12'd3413, 13'd1,    1'b0, '0},
        '{12'd2047, 13'd2048, 1'b0, '0},
        '{12'd2730, 13'd5461, 1'b0, '0},
        '{12'd1024, 13'd4095, 1'b0, '0},
        '{12'd3071, 13'd2730, 1'b0, '0}
    };

    task automatic send_pixel(logic [HB-1:0] hue, logic [SB:0] sat, bit typed, t_rgb rgb);
        while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
            pix_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.hue_angle <= hue;
        pix_in.sat_value <= sat;
        pending_rgb.push_back(typed ? rgb : hsi_to_rgb(hue, sat));
        @(posedge i_clk);
        while (!pix_in.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_and_set_level(logic [7:0] lvl);
        pix_in.valid <= 1'b0;
        while (pending_rgb.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= lvl;
        level_model = lvl;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_pixels(int n);
        logic [HB-1:0] hue;
        logic [SB:0] sat;
        for (int k = 0; k < n; k++) begin
            hue = HB'($urandom);
            case ($urandom_range(9))
                0: sat = 13'd0;
                1: sat = (SB+1)'($urandom_range(8191, 4097));
                2: sat = 13'd4096;
                default: sat = (SB+1)'($urandom_range(4096, 1));
            endcase
            send_pixel(hue, sat, 1'b0, '0);
        end
    endtask

    // receiver: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off)
            pix_out.ready <= 1'b0;
        else
            pix_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        pix_out.ready = 1'b0;
        wait (i_rst_n);
        repeat (200) @(posedge i_clk);
        @(negedge i_clk);
        hold_off = 1'b1;
        repeat (300) @(negedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin
        t_rgb got, want;
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            got = '{pix_out.red_out, pix_out.green_out, pix_out.blue_out};
            if (pending_rgb.size() == 0) begin
                $display("%0t: unexpected pixel %h", $time, got);
                errors++;
            end else begin
                want = pending_rgb.pop_front();
                if (got.red !== want.red)
                    $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
                if (got.green !== want.green)
                    $display("%0t: green expected %0d actual %0d", $time, want.green,
                             got.green);
                if (got.blue !== want.blue)
                    $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
                if (got !== want) errors++;
            end
        end
    end

    initial begin
        pix_in.valid = 1'b0;
        pix_in.hue_angle = '0;
        pix_in.sat_value = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[k])
            send_pixel(dir_rows[k].hue, dir_rows[k].sat, dir_rows[k].typed, dir_rows[k].rgb);
        drain_and_set_level(8'd255);
        foreach (dir_rows[k])
            send_pixel(dir_rows[k].hue, dir_rows[k].sat, 1'b0, '0);
        send_gap_pct = 9;
        recv_stall_pct = 58;
        random_pixels(330);
        drain_and_set_level(8'd1);
        random_pixels(100);
        drain_and_set_level(8'd85);
        send_gap_pct = 58;
        recv_stall_pct = 9;
        random_pixels(250);
        drain_and_set_level(8'($urandom_range(254, 2)));
        send_gap_pct = 0;
        recv_stall_pct = 0;
        random_pixels(300);
        pix_in.valid <= 1'b0;
        all_sent = 1'b1;
    end

    initial begin
        wait (all_sent);
        while (pending_rgb.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #3ms;
        $display("FAILURE");
        $finish;
    end
endmodule
